// ----- rtl/length_prefixed_message_deframer_unit_macros.svh -----
// assertion macros shared by the deframer rtl
// no dependencies; included by the modules that carry assertions
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LPMD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// next-cycle implication, disabled while in reset
`define LPMD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

// ----- rtl/lpmd_pkg.sv -----
// shared types and constants for the length-prefixed message deframer
// no dependencies
package lpmd_pkg;

	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned LEN_BYTES = 4;

	// parser phase
	typedef enum logic {
		PH_HEADER,
		PH_BODY
	} phase_t;

	// one result item
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [31:0] msg_type;
		logic [31:0] msg_length;
		logic        last;
	} result_t;

	localparam logic KIND_BODY  = 1'b0;
	localparam logic KIND_EMPTY = 1'b1;

endpackage

// ----- rtl/length_prefixed_message_deframer_unit.sv -----
// Length-prefixed message deframer, top level.
// Depends on lpmd_pkg, lpmd_in_reg, lpmd_core, lpmd_out_reg and the macro header.
//
// Input channel: one link byte per item on rx_byte, with in_valid / in_stall.
// Each message is an 8-byte header (32-bit little-endian body length, then
// 32-bit little-endian type) followed by the body. Header bytes give no item;
// each body byte gives one item with kind 0, the byte, type and length, and
// last set on the final byte. A zero-length header gives one item with kind 1,
// payload_byte 0, msg_length 0 and last 1.
// Throughput: one byte per clock while in_stall is low. An accepted byte is
// held in the input register, the parser works on it there, and its result
// is loaded into the output register when the parser consumes it.
// When out_stall is high with a result waiting, the held input byte waits and
// in_stall rises; the input register still takes a byte while the output
// register holds an earlier result that is being taken.
// Reset: asynchronous, active low; the parser restarts at a header boundary
// and both registers come up empty.
`include "length_prefixed_message_deframer_unit_macros.svh"
module length_prefixed_message_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [31:0] msg_type,
	output logic [31:0] msg_length,
	output logic        last
);
	import lpmd_pkg::*;

	logic       out_free;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_q;

	// input register
	lpmd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.step     (step)
	);

	// parser
	lpmd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	lpmd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_q     (out_q)
	);

	// output fields
	assign kind         = out_q.kind;
	assign payload_byte = out_q.payload_byte;
	assign msg_type     = out_q.msg_type;
	assign msg_length   = out_q.msg_length;
	assign last         = out_q.last;

	// input only stalls when a held byte is blocked by a waiting result
	`LPMD_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, valid_s1 && out_valid && out_stall)

endmodule

// ----- rtl/lpmd_in_reg.sv -----
// input register stage: holds one accepted byte until the parser takes it
// depends on nothing but the port handshake
module lpmd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_free,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       step
);

	logic accept;

	// parser consumes the held item when the result register can take a result
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// byte holding register
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ----- rtl/lpmd_core.sv -----
// header parser and body counter of the deframer
// depends on lpmd_pkg and the assertion macro header
`include "length_prefixed_message_deframer_unit_macros.svh"
module lpmd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_s1,
	output logic              res_valid,
	output lpmd_pkg::result_t res
);
	import lpmd_pkg::*;

	phase_t      phase_q;
	phase_t      phase_d;
	logic [31:0] count_q;
	logic [31:0] len_q;
	logic [31:0] type_q;

	logic [2:0]  pos;
	logic [4:0]  lane_shift;
	logic [31:0] shifted;
	logic [31:0] len_hdr;
	logic [31:0] type_hdr;
	logic        hdr_done;
	logic        body_fin;
	logic [31:0] count_inc;

	// byte lane placement, little-endian; lane zero restarts the word
	assign pos        = count_q[2:0];
	assign lane_shift = {pos[1:0], 3'b000};
	assign shifted    = {24'd0, byte_s1} << lane_shift;
	assign len_hdr    = (pos[1:0] == 2'd0) ? shifted : (len_q | shifted);
	assign type_hdr   = (pos[1:0] == 2'd0) ? shifted : (type_q | shifted);
	assign hdr_done   = (pos == 3'(HDR_BYTES - 1));
	assign count_inc  = count_q + 32'd1;
	assign body_fin   = (count_inc == len_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HEADER: begin
				if (step && hdr_done && (len_q != 32'd0)) begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				if (step && body_fin) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// result for the byte being consumed
	always_comb begin
		res_valid        = 1'b0;
		res.kind         = KIND_BODY;
		res.payload_byte = byte_s1;
		res.msg_type     = type_q;
		res.msg_length   = len_q;
		res.last         = body_fin;
		case (phase_q)
			PH_HEADER: begin
				res_valid        = step && hdr_done && (len_q == 32'd0);
				res.kind         = KIND_EMPTY;
				res.payload_byte = 8'd0;
				res.msg_type     = type_hdr;
				res.msg_length   = 32'd0;
				res.last         = 1'b1;
			end
			PH_BODY: begin
				res_valid = step;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= 32'd0;
			len_q   <= 32'd0;
			type_q  <= 32'd0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == PH_HEADER) begin
				if (pos < 3'(LEN_BYTES)) begin
					len_q <= len_hdr;
				end else begin
					type_q <= type_hdr;
				end
				count_q <= hdr_done ? 32'd0 : count_inc;
			end else begin
				count_q <= body_fin ? 32'd0 : count_inc;
			end
		end
	end

	// header position never leaves the eight header bytes
	`LPMD_ASSERT_IMP(a_hdr_count, clk, arst_n, phase_q == PH_HEADER, count_q[31:3] == 29'd0)
	// a body is only entered with a nonzero length
	`LPMD_ASSERT_IMP(a_body_len, clk, arst_n, phase_q == PH_BODY, len_q != 32'd0)
	// an empty message is always final and carries zero length
	`LPMD_ASSERT_IMP(a_empty_res, clk, arst_n, res_valid && res.kind == KIND_EMPTY,
		res.last && res.msg_length == 32'd0)

endmodule

// ----- rtl/lpmd_out_reg.sv -----
// result register on the output channel
// depends on lpmd_pkg and the assertion macro header
`include "length_prefixed_message_deframer_unit_macros.svh"
module lpmd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lpmd_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_stall,
	output lpmd_pkg::result_t out_q
);
	import lpmd_pkg::*;

	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	// a taken item with nothing new behind it leaves the register empty
	`LPMD_ASSERT_NXT(a_out_drain, clk, arst_n, out_valid_q && !out_stall && !load, !out_valid_q)

endmodule

// ----- sim/lpmd_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the length-prefixed message deframer: watches both channels,
// rebuilds the expected result items from the accepted link bytes and compares
// depends on lpmd_pkg
module lpmd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [7:0]  payload_byte,
	input  logic [31:0] msg_type,
	input  logic [31:0] msg_length,
	input  logic        last,
	output int          errors,
	output int          pending
);
	import lpmd_pkg::*;

	// own copy of the parser state
	phase_t      phase;
	logic [31:0] byte_idx;
	logic [31:0] length_word;
	logic [31:0] type_word;

	// result items still to come, oldest first
	result_t     expected_items[$];
	result_t     want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	// advance the parser by one link byte, queue the item it yields
	task automatic deframe_byte(input logic [7:0] b);
		logic [2:0] pos;
		result_t    item;
		pos = byte_idx[2:0];
		if (phase == PH_HEADER) begin
			// header words are assembled little-endian
			if (pos < LEN_BYTES) begin
				if (pos == 0)
					length_word = '0;
				length_word[pos[1:0]*8 +: 8] = b;
			end else begin
				if (pos == LEN_BYTES)
					type_word = '0;
				type_word[pos[1:0]*8 +: 8] = b;
			end
			if (byte_idx + 1 < HDR_BYTES) begin
				byte_idx = byte_idx + 1;
			end else begin
				byte_idx = '0;
				// zero length gives a single empty-message item
				if (length_word == 0) begin
					item.kind         = KIND_EMPTY;
					item.payload_byte = '0;
					item.msg_type     = type_word;
					item.msg_length   = '0;
					item.last         = 1'b1;
					expected_items.push_back(item);
				end else begin
					phase = PH_BODY;
				end
			end
		end else begin
			// body byte passes through, last on the final one
			item.kind         = KIND_BODY;
			item.payload_byte = b;
			item.msg_type     = type_word;
			item.msg_length   = length_word;
			item.last         = (byte_idx + 1 == length_word);
			expected_items.push_back(item);
			if (item.last) begin
				byte_idx = '0;
				phase    = PH_HEADER;
			end else begin
				byte_idx = byte_idx + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase       = PH_HEADER;
			byte_idx    = '0;
			length_word = '0;
			type_word   = '0;
			expected_items.delete();
			pending     = 0;
		end else begin
			// result side first, so a byte taken at this edge cannot match
			if (out_valid && !out_stall) begin
				if (expected_items.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected item kind %0d byte %02h type %08h length %08h last %0d",
							$realtime, kind, payload_byte, msg_type, msg_length, last);
				end else begin
					want = expected_items.pop_front();
					if (kind !== want.kind || payload_byte !== want.payload_byte ||
						msg_type !== want.msg_type || msg_length !== want.msg_length ||
						last !== want.last) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: item mismatch", $realtime);
							$display("  expected kind %0d byte %02h type %08h length %08h last %0d",
								want.kind, want.payload_byte, want.msg_type, want.msg_length,
								want.last);
							$display("  actual   kind %0d byte %02h type %08h length %08h last %0d",
								kind, payload_byte, msg_type, msg_length, last);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				deframe_byte(rx_byte);
			pending = expected_items.size();
		end
	end

endmodule

// ----- sim/tb_length_prefixed_message_deframer_unit.sv -----
`timescale 1ns / 100ps
// testbench top for the length-prefixed message deframer: drives framed byte
// streams and random stalls, gives the verdict; depends on lpmd_pkg, the rtl and lpmd_checker
module tb_length_prefixed_message_deframer_unit;
	import lpmd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [31:0] msg_type;
	logic [31:0] msg_length;
	logic        last;

	int          errors;
	int          pending;
	int          bytes_sent;
	bit          quiet;
	bit          hold_go;
	bit          hold_used;
	int          hold_left;

	length_prefixed_message_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.msg_type     (msg_type),
		.msg_length   (msg_length),
		.last         (last)
	);

	lpmd_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.msg_type     (msg_type),
		.msg_length   (msg_length),
		.last         (last),
		.errors       (errors),
		.pending      (pending)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// offer one link byte, with a random gap before it, until it is taken
	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
	endtask

	// 8-byte header: length then type, both little-endian
	task automatic send_header(input logic [31:0] len, input logic [31:0] typ);
		for (int i = 0; i < 4; i++)
			send_byte(len[i*8 +: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(typ[i*8 +: 8]);
	endtask

	task automatic send_body(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used = 1'b1;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 15);
		end
	end

	// stimulus
	initial begin
		int unsigned r;
		int unsigned len;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = '0;
		out_stall  = 1'b0;
		bytes_sent = 0;
		quiet      = 1'b0;
		hold_go    = 1'b0;
		hold_used  = 1'b0;
		hold_left  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message with an all-ones type
		send_header(32'h0, 32'hFFFF_FFFF);
		// one-byte body, all-zero type
		send_header(32'h1, 32'h0);
		send_byte(8'hFF);
		// two-byte body, the first byte all zeros
		send_header(32'h2, 32'h8000_0001);
		send_byte(8'h00);
		send_byte(8'h5A);

		// sender pauses until every result is out
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);

		// long body while the receiver holds off, so the input backs up
		send_header(32'd140, $urandom);
		hold_go = 1'b1;
		send_body(140);

		// random well-formed messages, a quiet window in the middle
		while (bytes_sent < 550) begin
			quiet = (bytes_sent >= 250 && bytes_sent < 400);
			r = $urandom_range(0, 99);
			if (r < 15)
				len = 0;
			else if (r < 80)
				len = $urandom_range(1, 12);
			else if (r < 97)
				len = $urandom_range(13, 48);
			else
				len = $urandom_range(256, 300);
			send_header(len, $urandom);
			send_body(len);
		end
		quiet = 1'b0;

		// maximum length: only the start of the body is streamed
		send_header(32'hFFFF_FFFF, $urandom);
		send_body(5);

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lpmd_pkg.sv
rtl/lpmd_in_reg.sv
rtl/lpmd_core.sv
rtl/lpmd_out_reg.sv
rtl/length_prefixed_message_deframer_unit.sv
sim/lpmd_checker.sv
sim/tb_length_prefixed_message_deframer_unit.sv
